// ===== src/rau_pkg.sv =====
// Package for the rational arithmetic unit: operation codes, status codes,
// controller states and the command/status structs. No dependencies.
package rau_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned FieldWidth    = 32;
  localparam int unsigned MagWidth      = 64;  // exact product magnitude
  localparam int unsigned ShWidth       = 7;   // common shift count, 0..64

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_CMP  = 3'd5,
    OP_NEG  = 3'd6,
    OP_ABS  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_COMB,
    S_GPREP,
    S_GSTRIP,
    S_GLOOP,
    S_DIVN,
    S_DIVD,
    S_FIN,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;     // capture operands and magnitudes
    logic mul;      // form the cross products
    logic comb;     // combine into one sign/magnitude fraction
    logic gprep;    // start the gcd
    logic gstrip;   // strip common factors of two
    logic gloop;    // one step of the binary gcd
    logic div_start;
    logic div_num;  // 0 quotient goes to denominator, 1 to numerator
    logic fin;      // range check, form result
  } rau_cmd_t;

  typedef struct packed {
    logic early;    // invalid operands, result already formed
    logic gdone_strip;
    logic gdone;
    logic div_busy;
  } rau_sts_t;

endpackage

// ===== src/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: exact fraction add/sub/mul/div/compare with gcd
// reduction. Each item passes load, cross products, combine, the binary gcd
// (strip, then shift/subtract), two bit-serial divisions and the range check;
// one item at a time, the next accepted only after the result is handed to the
// output register; invalid operands skip from load straight to the output.
// Reset (rst_ni low, asynchronous) returns the controller to idle with
// s_axis_tready high and clears m_axis_tvalid; no clearing pass.
module rational_arithmetic_unit #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::ValueWidthDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96]
  input  logic [127:0] s_axis_tdata,
  // tuser: kind[2:0]
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: res_num[31:0], res_den[62:32], less[63], equal[64], status[66:65],
  // zero fill [71:67]
  output logic [71:0]  m_axis_tdata
);
  import rau_pkg::*;

  rau_cmd_t cmd;
  rau_sts_t sts_dp;
  logic     busy, in_fire, ctrl_valid, handoff;
  logic [FieldWidth-1:0] res_num;
  logic [FieldWidth-2:0] res_den;
  logic       less, equal;
  logic [1:0] status;
  logic       out_valid_q;
  logic [71:0] out_data_q;

  assign s_axis_tready = !busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  // result moves to the output register when it is empty or draining
  assign handoff       = ctrl_valid && (!out_valid_q || m_axis_tready);

  // invalid items skip straight to the output: early is set at load
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .out_fire_i  (handoff),
    .sts_i       (sts_dp),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .out_valid_o (ctrl_valid)
  );

  rau_dp #(.VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .kind_i    (s_axis_tuser),
    .a_num_i   (s_axis_tdata[31:0]),
    .a_den_i   (s_axis_tdata[63:32]),
    .b_num_i   (s_axis_tdata[95:64]),
    .b_den_i   (s_axis_tdata[127:96]),
    .cmd_i     (cmd),
    .sts_o     (sts_dp),
    .res_num_o (res_num),
    .res_den_o (res_den),
    .less_o    (less),
    .equal_o   (equal),
    .status_o  (status)
  );

  // output register: a waiting result no longer blocks the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (handoff) begin
      out_valid_q <= 1'b1;
      out_data_q  <= {5'b0, status, equal, less, res_den, res_num};
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // a stalled result holds steady
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");
  // invalid result is always 0/0
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[66:65] == ST_INVALID) |->
    (m_axis_tdata[62:32] == '0 && !m_axis_tdata[63] && !m_axis_tdata[64]))
    else $error("invalid result not 0/0");
  // non-invalid result has a nonzero denominator
  a_den_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[66:65] != ST_INVALID) |-> (m_axis_tdata[62:32] != '0))
    else $error("zero denominator on valid result");

endmodule

// ===== src/rau_ctrl.sv =====
// Controller for the rational arithmetic unit: sequences load, products,
// gcd and the two exact divisions. Depends on rau_pkg.
module rau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              out_fire_i,
  input  rau_pkg::rau_sts_t sts_i,
  output rau_pkg::rau_cmd_t cmd_o,
  output logic              busy_o,
  output logic              out_valid_o
);
  import rau_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy_o = 1'b0;
        if (in_fire_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        if (sts_i.early) begin
          state_d = S_OUT;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_COMB;
        end
      end
      S_COMB: begin
        cmd_o.comb = 1'b1;
        state_d    = S_GPREP;
      end
      S_GPREP: begin
        cmd_o.gprep = 1'b1;
        state_d     = S_GSTRIP;
      end
      S_GSTRIP: begin
        if (sts_i.gdone_strip) begin
          state_d = S_GLOOP;
        end else begin
          cmd_o.gstrip = 1'b1;
        end
      end
      S_GLOOP: begin
        if (sts_i.gdone) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_num   = 1'b1;
          state_d         = S_DIVN;
        end else begin
          cmd_o.gloop = 1'b1;
        end
      end
      S_DIVN: begin
        cmd_o.div_num = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_num   = 1'b0;
          state_d         = S_DIVD;
        end
      end
      S_DIVD: begin
        if (!sts_i.div_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_fire_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== src/rau_div.sv =====
// Restoring divider for the exact division by the gcd, one quotient bit a
// cycle. Depends on rau_pkg.
module rau_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [rau_pkg::MagWidth-1:0]   dividend_i,
  input  logic [rau_pkg::MagWidth-1:0]   divisor_i,
  output logic                           busy_o,
  output logic [rau_pkg::MagWidth-1:0]   quot_o
);
  import rau_pkg::*;

  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic [MagWidth-1:0] quo_q, quo_d;
  logic [MagWidth-1:0] rem_q, rem_d;
  logic [MagWidth-1:0] dvs_q, dvs_d;
  logic [MagWidth:0]   trial;

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    trial = {rem_q, quo_q[MagWidth-1]};
    if (start_i) begin
      cnt_d = CntWidth'(MagWidth);
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = MagWidth'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[MagWidth-2:0], 1'b1};
      end else begin
        rem_d = trial[MagWidth-1:0];
        quo_d = {quo_q[MagWidth-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  // registered only: the controller decides start from this flag
  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;

endmodule

// ===== src/rau_dp.sv =====
// Datapath for the rational arithmetic unit: operand load, cross products,
// sign/magnitude combine, binary gcd, divider and range check.
// Depends on rau_pkg and rau_div.
module rau_dp #(
  parameter int unsigned VALUE_WIDTH = rau_pkg::ValueWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_fire_i,
  input  logic [2:0]                       kind_i,
  input  logic [rau_pkg::FieldWidth-1:0]   a_num_i,
  input  logic [rau_pkg::FieldWidth-1:0]   a_den_i,
  input  logic [rau_pkg::FieldWidth-1:0]   b_num_i,
  input  logic [rau_pkg::FieldWidth-1:0]   b_den_i,
  input  rau_pkg::rau_cmd_t                cmd_i,
  output rau_pkg::rau_sts_t                sts_o,
  output logic [rau_pkg::FieldWidth-1:0]   res_num_o,
  output logic [rau_pkg::FieldWidth-2:0]   res_den_o,
  output logic                             less_o,
  output logic                             equal_o,
  output logic [1:0]                       status_o
);
  import rau_pkg::*;

  localparam int unsigned HalfW = FieldWidth;

  // raw item
  op_e                 kind_q;
  logic [HalfW-1:0]    an_q, ad_q, bn_q, bd_q;
  // magnitudes and signs
  logic [HalfW-1:0]    man_q, mad_q, mbn_q, mbd_q;
  logic                sa_q, sb_q;
  // products
  logic [MagWidth-1:0] p_q, q_q, dd_q;
  logic                rneg_q;
  logic [MagWidth-1:0] rn_q, rd_q;
  // gcd
  logic [MagWidth-1:0] gx_q, gy_q;
  logic [ShWidth-1:0]  sh_q;
  logic                gzero_q;
  // outputs
  logic                early_q;
  logic [FieldWidth-1:0]   onum_q;
  logic [FieldWidth-2:0]   oden_q;
  logic                less_q, equal_q;
  logic [1:0]          status_q;

  logic                div_busy;
  logic [MagWidth-1:0] quot;
  logic [MagWidth-1:0] div_dvd;
  logic [MagWidth-1:0] gval;

  function automatic logic [HalfW-1:0] mag32(input logic [HalfW-1:0] v);
    mag32 = v[HalfW-1] ? (~v + 1'b1) : v;
  endfunction

  // operand capture and magnitudes
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      kind_q <= op_e'(kind_i);
      an_q   <= a_num_i;
      ad_q   <= a_den_i;
      bn_q   <= b_num_i;
      bd_q   <= b_den_i;
    end
    if (cmd_i.load) begin
      man_q <= mag32(an_q);
      mad_q <= mag32(ad_q);
      mbn_q <= mag32(bn_q);
      mbd_q <= mag32(bd_q);
      sa_q  <= (an_q[HalfW-1] != ad_q[HalfW-1]) && (an_q != '0);
      sb_q  <= (bn_q[HalfW-1] != bd_q[HalfW-1]) && (bn_q != '0);
    end
  end

  // invalid operand detection on the raw item
  logic uses_b, bad;
  always_comb begin
    uses_b = !(kind_q == OP_NORM || kind_q == OP_NEG || kind_q == OP_ABS);
    bad    = (ad_q == '0) || (uses_b && (bd_q == '0)) ||
             ((kind_q == OP_DIV) && (bn_q == '0));
  end

  // cross products, one 32x32 multiplier each
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      unique case (kind_q)
        OP_MUL: begin
          p_q  <= MagWidth'(man_q * mbn_q);
          dd_q <= MagWidth'(mad_q * mbd_q);
        end
        OP_DIV: begin
          p_q  <= MagWidth'(man_q * mbd_q);
          dd_q <= MagWidth'(mad_q * mbn_q);
        end
        OP_NORM, OP_NEG, OP_ABS: begin
          p_q  <= MagWidth'(man_q);
          dd_q <= MagWidth'(mad_q);
        end
        default: begin
          p_q  <= MagWidth'(man_q * mbd_q);
          dd_q <= MagWidth'(mad_q * mbd_q);
        end
      endcase
      q_q <= MagWidth'(mbn_q * mad_q);
    end
  end

  // combine, compare flags
  logic sq_eff;
  logic cmp_less, cmp_equal;
  always_comb begin
    sq_eff    = (kind_q == OP_SUB) ? ~sb_q : sb_q;
    cmp_equal = (sa_q == sb_q) && (p_q == q_q);
    unique case ({sa_q, sb_q})
      2'b10:   cmp_less = 1'b1;
      2'b01:   cmp_less = 1'b0;
      2'b00:   cmp_less = p_q < q_q;
      default: cmp_less = p_q > q_q;
    endcase
  end

  // compare reduces a itself, so its denominator is a's own
  always_ff @(posedge clk_i) begin
    if (cmd_i.comb) begin
      rd_q    <= (kind_q == OP_CMP) ? MagWidth'(mad_q) : dd_q;
      less_q  <= (kind_q == OP_CMP) && cmp_less;
      equal_q <= (kind_q == OP_CMP) && cmp_equal;
      unique case (kind_q)
        OP_ADD, OP_SUB: begin
          if (sa_q == sq_eff) begin
            rn_q   <= p_q + q_q;
            rneg_q <= sa_q && ((p_q + q_q) != '0);
          end else if (p_q >= q_q) begin
            rn_q   <= p_q - q_q;
            rneg_q <= sa_q && (p_q != q_q);
          end else begin
            rn_q   <= q_q - p_q;
            rneg_q <= sq_eff;
          end
        end
        OP_MUL, OP_DIV: begin
          rn_q   <= p_q;
          rneg_q <= (sa_q != sb_q) && (p_q != '0);
        end
        OP_CMP: begin
          rn_q   <= MagWidth'(man_q);
          rneg_q <= sa_q;
        end
        OP_NEG: begin
          rn_q   <= p_q;
          rneg_q <= !sa_q && (p_q != '0);
        end
        OP_ABS: begin
          rn_q   <= p_q;
          rneg_q <= 1'b0;
        end
        default: begin
          rn_q   <= p_q;
          rneg_q <= sa_q;
        end
      endcase
    end
  end

  // binary gcd, one shift or subtract per cycle
  logic [MagWidth-1:0] ys, gmin, gmax;
  always_comb begin
    ys   = gy_q;
    gmin = gx_q;
    gmax = gy_q;
    if (!gy_q[0]) begin
      ys = gy_q >> 1;
    end else if (gx_q > gy_q) begin
      gmin = gy_q;
      gmax = gx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gprep) begin
      gx_q    <= rn_q;
      gy_q    <= rd_q;
      sh_q    <= '0;
      gzero_q <= (rn_q == '0);
    end else if (cmd_i.gstrip) begin
      if (!gx_q[0] && !gy_q[0]) begin
        gx_q <= gx_q >> 1;
        gy_q <= gy_q >> 1;
        sh_q <= sh_q + 1'b1;
      end else begin
        gx_q <= gx_q >> 1;
      end
    end else if (cmd_i.gloop) begin
      if (!gy_q[0]) begin
        gy_q <= ys;
      end else begin
        gx_q <= gmin;
        gy_q <= gmax - gmin;
      end
    end
  end

  // zero numerator: gcd is the denominator itself; strip ends when x is odd
  assign sts_o.gdone_strip = gzero_q || gx_q[0];
  assign sts_o.gdone       = gzero_q || (gy_q == '0);
  assign sts_o.div_busy    = div_busy;
  assign sts_o.early       = early_q;

  assign gval    = gzero_q ? rd_q : (gx_q << sh_q);
  assign div_dvd = cmd_i.div_num ? rn_q : rd_q;

  rau_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dvd),
    .divisor_i  (gval),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // latch the reduced numerator when the second division starts
  logic [MagWidth-1:0] qn_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start && !cmd_i.div_num) begin
      qn_q <= quot;
    end
  end

  // range check and result formation
  localparam logic [MagWidth-1:0] Lim = MagWidth'(1) << (VALUE_WIDTH - 1);
  logic                ovf;
  logic [MagWidth-1:0] sn;
  always_comb begin
    ovf = (rneg_q ? (qn_q > Lim) : (qn_q >= Lim)) || (quot >= Lim);
    sn  = rneg_q ? (~qn_q + 1'b1) : qn_q;
  end

  // invalid operands, flagged at load for the controller and the flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      early_q <= 1'b0;
    end else if (cmd_i.load) begin
      early_q <= bad;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      onum_q   <= '0;
      oden_q   <= '0;
      status_q <= ST_INVALID;
    end else if (cmd_i.fin) begin
      if (qn_q == '0) begin
        onum_q   <= '0;
        oden_q   <= (FieldWidth-1)'(1);
        status_q <= ST_OK;
      end else if (ovf) begin
        onum_q   <= '0;
        oden_q   <= (FieldWidth-1)'(1);
        status_q <= ST_OVERFLOW;
      end else begin
        onum_q   <= sn[FieldWidth-1:0];
        oden_q   <= quot[FieldWidth-2:0];
        status_q <= ST_OK;
      end
    end
  end

  assign res_num_o = onum_q;
  assign res_den_o = oden_q;
  assign less_o    = early_q ? 1'b0 : less_q;
  assign equal_o   = early_q ? 1'b0 : equal_q;
  assign status_o  = status_q;

endmodule
